/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication with asynchronous reset disable
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* design/tfg_pkg.sv */
// Package: constants, types and the arctangent table of the twiddle generator.
package tfg_pkg;
	localparam int MAX_LENGTH_DEF = 4096;
	localparam int FRAC_BITS_DEF = 16;
	localparam int LEN_W = 13;
	localparam int IDX_W = 16;
	localparam int VAL_W = 18;
	localparam int CORDIC_STEPS = 24;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BUILT = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DIV, S_LOOK_RD, S_LOOK_WAIT, S_LOOK_OUT,
		S_B_INIT, S_B_PHASE, S_B_ZMUL, S_B_CORDIC, S_B_QUAD,
		S_B_RD, S_B_WAIT, S_B_MUL, S_B_SUM, S_B_WR, S_B_DONE
	} state_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] k);
		case (k)
			5'd0: atan_q30 = 32'd843314856;
			5'd1: atan_q30 = 32'd497837829;
			5'd2: atan_q30 = 32'd263043836;
			5'd3: atan_q30 = 32'd133525158;
			5'd4: atan_q30 = 32'd67021686;
			5'd5: atan_q30 = 32'd33543515;
			5'd6: atan_q30 = 32'd16775850;
			5'd7: atan_q30 = 32'd8388437;
			5'd8: atan_q30 = 32'd4194282;
			5'd9: atan_q30 = 32'd2097149;
			5'd10: atan_q30 = 32'd1048575;
			5'd11: atan_q30 = 32'd524287;
			5'd12: atan_q30 = 32'd262143;
			5'd13: atan_q30 = 32'd131071;
			5'd14: atan_q30 = 32'd65535;
			5'd15: atan_q30 = 32'd32767;
			5'd16: atan_q30 = 32'd16383;
			5'd17: atan_q30 = 32'd8191;
			5'd18: atan_q30 = 32'd4095;
			5'd19: atan_q30 = 32'd2047;
			5'd20: atan_q30 = 32'd1023;
			5'd21: atan_q30 = 32'd511;
			5'd22: atan_q30 = 32'd255;
			5'd23: atan_q30 = 32'd127;
			default: atan_q30 = 32'd0;
		endcase
	endfunction
endpackage

/* design/tfg_divider.sv */
// Restoring divider: quotient and remainder of a 48-bit numerator by a 17-bit divisor.
module tfg_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [47:0] num,
	input  logic [16:0] den,
	output logic        done,
	output logic [47:0] quot,
	output logic [16:0] rem
);
	logic [5:0] cnt_q;
	logic busy_q;
	logic [47:0] q_q;
	logic [17:0] r_q;
	logic [17:0] trial;

	assign trial = {r_q[16:0], q_q[47]} - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num;
			r_q <= '0;
		end else if (busy_q) begin
			if (!trial[17]) begin
				r_q <= trial;
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				r_q <= {r_q[16:0], q_q[47]};
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem = r_q[16:0];
endmodule

/* design/twiddle_factor_generator_core.sv */
// Top level: twiddle factor generator with base table in a synchronous RAM.
// One word per item, one strobe cycle, the receiver cannot stall. For a lookup on
// a built table, a 48-step bit-serial divider reduces the index modulo the length,
// then up to three symmetry folds end in one RAM read. A build runs one 24-step
// CORDIC per doubling level and steps each table entry through the read, wait,
// multiply, sum and write states on the RAM.
module twiddle_factor_generator_core #(
	parameter int MAX_LENGTH = tfg_pkg::MAX_LENGTH_DEF,
	parameter int FRAC_BITS = tfg_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic kind,
	input  logic [tfg_pkg::IDX_W-1:0] index,
	input  logic length_we,
	input  logic [tfg_pkg::LEN_W-1:0] length_wdata,
	output logic done,
	output logic signed [tfg_pkg::VAL_W-1:0] sin_value,
	output logic signed [tfg_pkg::VAL_W-1:0] cos_value,
	output logic [1:0] status
);
	localparam int DEPTH = MAX_LENGTH / 2 + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int EW = FRAC_BITS + 2;
	localparam logic signed [EW-1:0] ONE = EW'(1) <<< FRAC_BITS;

	tfg_pkg::state_t state_q, state_d;
	logic [tfg_pkg::LEN_W-1:0] len_q;
	logic ready_q;
	logic [16:0] n_q;
	logic [AW:0] nmax, vl_q, i_q, lim_q;
	logic [16:0] m_q;
	logic neg_s_q, neg_c_q, swap_q;
	logic [2:0] fold_q;

	logic [2*EW-1:0] mem [DEPTH];
	logic [AW-1:0] raddr, waddr;
	logic [2*EW-1:0] rdata_q, wdata;
	logic we;

	logic div_go, div_done;
	logic [47:0] div_num, div_quot;
	logic [16:0] div_rem;

	logic [31:0] phase_q;
	logic signed [33:0] x_q, y_q, z_q, ca_q, sa_q;
	logic [4:0] k_q;
	logic signed [EW+34:0] p1_q, p2_q, p3_q, p4_q;
	logic signed [EW-1:0] ns_q, nc_q;

	tfg_divider u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(div_num), .den(n_q),
		.done(div_done), .quot(div_quot), .rem(div_rem)
	);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign nmax = (n_q[1:0] == 2'b00) ? (AW+1)'((n_q >> 3) + 17'd1) :
		(!n_q[0]) ? (AW+1)'((n_q >> 2) + 17'd1) : (AW+1)'((n_q >> 1) + 17'd1);

	function automatic logic signed [EW-1:0] rnd_sat(input logic signed [EW+35:0] v);
		logic [EW+35:0] a;
		logic [EW+35:0] r;
		logic signed [EW+35:0] s;
		a = v[EW+35] ? -v : v;
		r = (a + ((EW+36)'(1) << 29)) >> 30;
		s = v[EW+35] ? -$signed(r) : $signed(r);
		if (s > $signed((EW+36)'(ONE))) rnd_sat = ONE;
		else if (s < -$signed((EW+36)'(ONE))) rnd_sat = -ONE;
		else rnd_sat = s[EW-1:0];
	endfunction

	function automatic logic signed [33:0] clamp30(input logic signed [33:0] v);
		if (v > 34'sd1073741824) clamp30 = 34'sd1073741824;
		else if (v < -34'sd1073741824) clamp30 = -34'sd1073741824;
		else clamp30 = v;
	endfunction

	function automatic logic signed [33:0] fshr(input logic signed [33:0] v,
			input logic [4:0] k);
		fshr = v >>> k;
	endfunction

	assign busy = (state_q != tfg_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tfg_pkg::S_IDLE:
				if (start) begin
					if (!kind) state_d = tfg_pkg::S_B_INIT;
					else if (!ready_q) state_d = tfg_pkg::S_LOOK_OUT;
					else state_d = tfg_pkg::S_DIV;
				end
			tfg_pkg::S_DIV: if (div_done) state_d = tfg_pkg::S_LOOK_RD;
			tfg_pkg::S_LOOK_RD: if (fold_q == 3'd0) state_d = tfg_pkg::S_LOOK_WAIT;
			tfg_pkg::S_LOOK_WAIT: state_d = tfg_pkg::S_LOOK_OUT;
			tfg_pkg::S_LOOK_OUT: state_d = tfg_pkg::S_IDLE;
			tfg_pkg::S_B_INIT:
				state_d = (vl_q < nmax) ? tfg_pkg::S_B_PHASE : tfg_pkg::S_B_DONE;
			tfg_pkg::S_B_PHASE: if (div_done) state_d = tfg_pkg::S_B_ZMUL;
			tfg_pkg::S_B_ZMUL: state_d = tfg_pkg::S_B_CORDIC;
			tfg_pkg::S_B_CORDIC:
				if (k_q == 5'(tfg_pkg::CORDIC_STEPS - 1)) state_d = tfg_pkg::S_B_QUAD;
			tfg_pkg::S_B_QUAD: state_d = tfg_pkg::S_B_RD;
			tfg_pkg::S_B_RD: state_d = tfg_pkg::S_B_WAIT;
			tfg_pkg::S_B_WAIT: state_d = tfg_pkg::S_B_MUL;
			tfg_pkg::S_B_MUL: state_d = tfg_pkg::S_B_SUM;
			tfg_pkg::S_B_SUM: state_d = tfg_pkg::S_B_WR;
			tfg_pkg::S_B_WR:
				if (i_q + 1'b1 < lim_q) state_d = tfg_pkg::S_B_RD;
				else if ((vl_q << 1) < nmax) state_d = tfg_pkg::S_B_PHASE;
				else state_d = tfg_pkg::S_B_DONE;
			tfg_pkg::S_B_DONE: state_d = tfg_pkg::S_IDLE;
			default: state_d = tfg_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		div_go = 1'b0;
		div_num = '0;
		if (state_q == tfg_pkg::S_IDLE && start && kind && ready_q) begin
			div_go = 1'b1;
			div_num = 48'(index);
		end else if ((state_q == tfg_pkg::S_B_INIT && vl_q < nmax) ||
				(state_q == tfg_pkg::S_B_WR && !(i_q + 1'b1 < lim_q) &&
				(vl_q << 1) < nmax)) begin
			div_go = 1'b1;
			div_num = (state_q == tfg_pkg::S_B_INIT) ? {16'(vl_q), 32'd0} :
				{16'(vl_q << 1), 32'd0};
		end
		raddr = (state_q == tfg_pkg::S_B_RD || state_q == tfg_pkg::S_B_WAIT) ?
			AW'(i_q - vl_q) : AW'(m_q);
		we = (state_q == tfg_pkg::S_B_WR) || (state_q == tfg_pkg::S_B_INIT);
		waddr = (state_q == tfg_pkg::S_B_WR) ? AW'(i_q) : '0;
		wdata = (state_q == tfg_pkg::S_B_WR) ? {ns_q, nc_q} : {EW'(0), ONE};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfg_pkg::S_IDLE;
			len_q <= tfg_pkg::LEN_W'(1);
			ready_q <= 1'b0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == tfg_pkg::S_LOOK_OUT) || (state_q == tfg_pkg::S_B_DONE);
			if (length_we) begin
				len_q <= length_wdata;
				ready_q <= 1'b0;
			end else if (state_q == tfg_pkg::S_B_DONE) begin
				ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tfg_pkg::S_IDLE: begin
				if (len_q == '0) n_q <= 17'd1;
				else if (32'(len_q) > MAX_LENGTH) n_q <= 17'(MAX_LENGTH);
				else n_q <= 17'(len_q);
				neg_s_q <= 1'b0;
				neg_c_q <= 1'b0;
				swap_q <= 1'b0;
				fold_q <= 3'd3;
				vl_q <= (AW+1)'(1);
			end
			tfg_pkg::S_DIV: begin
				m_q <= div_rem;
			end
			tfg_pkg::S_LOOK_RD: begin
				if (17'(m_q) < 17'(nmax)) begin
					fold_q <= 3'd0;
				end else if (n_q[1:0] == 2'b00 && m_q <= (n_q >> 2)) begin
					m_q <= (n_q >> 2) - m_q;
					swap_q <= 1'b1;
					fold_q <= 3'd0;
				end else if (!n_q[0] && m_q <= (n_q >> 1)) begin
					m_q <= (n_q >> 1) - m_q;
					neg_c_q <= ~neg_c_q;
				end else begin
					m_q <= n_q - m_q;
					neg_s_q <= ~neg_s_q;
				end
			end
			tfg_pkg::S_B_PHASE: begin
				phase_q <= div_quot[31:0];
				i_q <= vl_q;
				lim_q <= ((vl_q << 1) > nmax) ? nmax : (vl_q << 1);
			end
			tfg_pkg::S_B_ZMUL: begin
				z_q <= 34'((64'(phase_q[29:0]) * 64'(tfg_pkg::HALF_PI_Q30)) >> 30);
				x_q <= tfg_pkg::CORDIC_GAIN;
				y_q <= '0;
				k_q <= '0;
			end
			tfg_pkg::S_B_CORDIC: begin
				k_q <= k_q + 5'd1;
				if (!z_q[33]) begin
					x_q <= x_q - fshr(y_q, k_q);
					y_q <= y_q + fshr(x_q, k_q);
					z_q <= z_q - $signed({2'b00, tfg_pkg::atan_q30(k_q)});
				end else begin
					x_q <= x_q + fshr(y_q, k_q);
					y_q <= y_q - fshr(x_q, k_q);
					z_q <= z_q + $signed({2'b00, tfg_pkg::atan_q30(k_q)});
				end
			end
			tfg_pkg::S_B_QUAD: begin
				case (phase_q[31:30])
					2'd0: begin ca_q <= clamp30(x_q); sa_q <= clamp30(y_q); end
					2'd1: begin ca_q <= clamp30(-y_q); sa_q <= clamp30(x_q); end
					2'd2: begin ca_q <= clamp30(-x_q); sa_q <= clamp30(-y_q); end
					default: begin ca_q <= clamp30(y_q); sa_q <= clamp30(-x_q); end
				endcase
			end
			tfg_pkg::S_B_MUL: begin
				p1_q <= $signed(rdata_q[2*EW-1:EW]) * ca_q;
				p2_q <= $signed(rdata_q[EW-1:0]) * sa_q;
				p3_q <= $signed(rdata_q[EW-1:0]) * ca_q;
				p4_q <= $signed(rdata_q[2*EW-1:EW]) * sa_q;
			end
			tfg_pkg::S_B_SUM: begin
				ns_q <= rnd_sat((EW+36)'(p1_q) + (EW+36)'(p2_q));
				nc_q <= rnd_sat((EW+36)'(p3_q) - (EW+36)'(p4_q));
			end
			tfg_pkg::S_B_WR: begin
				i_q <= i_q + 1'b1;
				if (!(i_q + 1'b1 < lim_q)) vl_q <= vl_q << 1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == tfg_pkg::S_LOOK_OUT) begin
			if (!ready_q) begin
				sin_value <= '0;
				cos_value <= '0;
				status <= tfg_pkg::ST_EMPTY;
			end else begin
				logic signed [EW-1:0] s, c;
				s = swap_q ? rdata_q[EW-1:0] : rdata_q[2*EW-1:EW];
				c = swap_q ? rdata_q[2*EW-1:EW] : rdata_q[EW-1:0];
				sin_value <= tfg_pkg::VAL_W'(neg_s_q ? -s : s);
				cos_value <= tfg_pkg::VAL_W'(neg_c_q ? -c : c);
				status <= tfg_pkg::ST_OK;
			end
		end else if (state_q == tfg_pkg::S_B_DONE) begin
			sin_value <= '0;
			cos_value <= '0;
			status <= tfg_pkg::ST_BUILT;
		end
	end
endmodule

/* design/tfg_checker.sv */
// Port-level checker for the twiddle factor generator, bound to the top level.
`include "assert_macros.svh"
module tfg_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic kind,
	input logic done,
	input logic [1:0] status,
	input logic signed [17:0] sin_value,
	input logic signed [17:0] cos_value
);
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "no busy after start")
	`ASSERT_IMPL(a_status_code, clk, arst_n, done, status <= tfg_pkg::ST_EMPTY, "bad status code")
	`ASSERT_IMPL(a_zero_vals, clk, arst_n, done && status != tfg_pkg::ST_OK,
		sin_value == 18'sd0 && cos_value == 18'sd0, "nonzero values on non-lookup")
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done held two cycles")
endmodule

bind twiddle_factor_generator_core tfg_checker u_tfg_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
	.done(done), .status(status), .sin_value(sin_value), .cos_value(cos_value)
);

/* tb/tb_twiddle_factor_generator_core.sv */
// Testbench for the twiddle factor generator: directed table plus random lookups and builds.
`timescale 1ns / 100ps

module tb_twiddle_factor_generator_core;
	localparam int WDOG_LIMIT = 40000;
	localparam int DEPTH = tfg_pkg::MAX_LENGTH_DEF / 2 + 1;
	localparam longint ONE_Q = longint'(1) << tfg_pkg::FRAC_BITS_DEF;
	localparam longint ONE_Q30 = longint'(1) << 30;

	typedef enum logic {ROW_LEN, ROW_WORD} row_act_t;

	typedef struct {
		row_act_t act;
		logic kind;
		logic [15:0] val;
		bit known;
		logic signed [tfg_pkg::VAL_W-1:0] s;
		logic signed [tfg_pkg::VAL_W-1:0] c;
		tfg_pkg::status_t st;
	} dir_row_t;

	typedef struct {
		logic signed [tfg_pkg::VAL_W-1:0] s;
		logic signed [tfg_pkg::VAL_W-1:0] c;
		tfg_pkg::status_t st;
	} twiddle_word_t;

	logic clk, arst_n, start, busy, kind, length_we, done;
	logic [tfg_pkg::IDX_W-1:0] index;
	logic [tfg_pkg::LEN_W-1:0] length_wdata;
	logic signed [tfg_pkg::VAL_W-1:0] sin_value, cos_value;
	logic [1:0] status;

	twiddle_factor_generator_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.index(index), .length_we(length_we), .length_wdata(length_wdata),
		.done(done), .sin_value(sin_value), .cos_value(cos_value), .status(status)
	);

	// predictor state
	int tab_s[DEPTH];
	int tab_c[DEPTH];
	bit tab_ready;
	int unsigned len_reg;
	const longint atan_tab[24] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127
	};

	twiddle_word_t twiddle_q[$];
	int errors, n_words, n_results, n_builds, n_lookups, n_lens;
	int idle_pct;

	const dir_row_t dir_tab[] = '{
		'{ROW_WORD, 1'b1, 16'd0, 1, 0, 0, tfg_pkg::ST_EMPTY},
		'{ROW_WORD, 1'b0, 16'd0, 1, 0, 0, tfg_pkg::ST_BUILT},
		'{ROW_WORD, 1'b1, 16'd0, 1, 0, 65536, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b1, 16'hFFFF, 1, 0, 65536, tfg_pkg::ST_OK},
		'{ROW_LEN, 1'b0, 16'd8, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b1, 16'd5, 1, 0, 0, tfg_pkg::ST_EMPTY},
		'{ROW_WORD, 1'b0, 16'd0, 1, 0, 0, tfg_pkg::ST_BUILT},
		'{ROW_WORD, 1'b1, 16'd0, 1, 0, 65536, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b1, 16'd1, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b1, 16'd2, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b1, 16'd3, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b1, 16'd4, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b1, 16'd6, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b1, 16'hFFFF, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_LEN, 1'b0, 16'd12, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b0, 16'd0, 1, 0, 0, tfg_pkg::ST_BUILT},
		'{ROW_WORD, 1'b1, 16'd3, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b1, 16'd9, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_LEN, 1'b0, 16'd7, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b0, 16'd0, 1, 0, 0, tfg_pkg::ST_BUILT},
		'{ROW_WORD, 1'b1, 16'd1, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b1, 16'd6, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_LEN, 1'b0, 16'd0, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b0, 16'd0, 1, 0, 0, tfg_pkg::ST_BUILT},
		'{ROW_WORD, 1'b1, 16'd1234, 1, 0, 65536, tfg_pkg::ST_OK},
		'{ROW_LEN, 1'b0, 16'd8191, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b0, 16'd0, 1, 0, 0, tfg_pkg::ST_BUILT},
		'{ROW_WORD, 1'b1, 16'd4096, 0, 0, 0, tfg_pkg::ST_OK},
		'{ROW_WORD, 1'b1, 16'hFFFF, 0, 0, 0, tfg_pkg::ST_OK}
	};

	function automatic int unsigned eff_length();
		if (len_reg == 0) return 1;
		if (len_reg > tfg_pkg::MAX_LENGTH_DEF) return tfg_pkg::MAX_LENGTH_DEF;
		return len_reg;
	endfunction

	function automatic int unsigned base_span(int unsigned n);
		if ((n & 3) == 0) return n / 8 + 1;
		if ((n & 1) == 0) return n / 4 + 1;
		return n / 2 + 1;
	endfunction

	function automatic longint clip(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint round30(longint v);
		if (v >= 0) return (v + (longint'(1) << 29)) >>> 30;
		return -((-v + (longint'(1) << 29)) >>> 30);
	endfunction

	function automatic void angle_rot(input int unsigned num, input int unsigned n,
			output longint sa, output longint ca);
		longint unsigned turns;
		logic [31:0] p;
		logic [63:0] rest;
		longint x, y, z, xs, ys, cs, sn;
		turns = (longint'(num) << 32) / n;
		p = turns[31:0];
		rest = {34'd0, p[29:0]};
		z = longint'((rest * 64'd1686629713) >> 30);
		x = 652032874;
		y = 0;
		for (int k = 0; k < 24; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - atan_tab[k];
			end else begin
				x = x + ys; y = y - xs; z = z + atan_tab[k];
			end
		end
		case (p[31:30])
			2'd0: begin cs = x; sn = y; end
			2'd1: begin cs = -y; sn = x; end
			2'd2: begin cs = -x; sn = -y; end
			default: begin cs = y; sn = -x; end
		endcase
		ca = clip(cs, ONE_Q30);
		sa = clip(sn, ONE_Q30);
	endfunction

	function automatic void fill_base();
		int unsigned n, nmax, lim;
		longint sa, ca, ps, pc;
		n = eff_length();
		nmax = base_span(n);
		tab_s[0] = 0;
		tab_c[0] = int'(ONE_Q);
		for (int unsigned vl = 1; vl < nmax; vl = vl << 1) begin
			angle_rot(vl, n, sa, ca);
			lim = (2 * vl > nmax) ? nmax : 2 * vl;
			for (int unsigned i = vl; i < lim; i++) begin
				ps = tab_s[i - vl];
				pc = tab_c[i - vl];
				tab_s[i] = int'(clip(round30(ps * ca + pc * sa), ONE_Q));
				tab_c[i] = int'(clip(round30(pc * ca - ps * sa), ONE_Q));
			end
		end
		tab_ready = 1;
	endfunction

	function automatic void base_fetch(input int unsigned m, input int unsigned n,
			output int s, output int c);
		if (m < base_span(n)) begin
			s = tab_s[m]; c = tab_c[m];
		end else if ((n & 3) == 0 && m <= n / 4) begin
			s = tab_c[n / 4 - m]; c = tab_s[n / 4 - m];
		end else if ((n & 1) == 0 && m <= n / 2) begin
			base_fetch(n / 2 - m, n, s, c);
			c = -c;
		end else begin
			base_fetch(n - m, n, s, c);
			s = -s;
		end
	endfunction

	function automatic twiddle_word_t twiddle_predict(logic k, logic [15:0] idx);
		twiddle_word_t w;
		int s, c;
		int unsigned n;
		s = 0;
		c = 0;
		if (!k) begin
			fill_base();
			w.st = tfg_pkg::ST_BUILT;
		end else if (!tab_ready) begin
			w.st = tfg_pkg::ST_EMPTY;
		end else begin
			n = eff_length();
			base_fetch(int'(idx) % n, n, s, c);
			w.st = tfg_pkg::ST_OK;
		end
		w.s = s[tfg_pkg::VAL_W-1:0];
		w.c = c[tfg_pkg::VAL_W-1:0];
		return w;
	endfunction

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// result check
	always @(posedge clk) begin
		if (arst_n && done) begin
			n_results++;
			if (twiddle_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word sin=%0d cos=%0d status=%0d", $time,
					sin_value, cos_value, status);
			end else begin
				if (sin_value !== twiddle_q[0].s || cos_value !== twiddle_q[0].c ||
						status !== twiddle_q[0].st) begin
					errors++;
					$display("%0t: mismatch expected sin=%0d cos=%0d status=%0d, got %0d %0d %0d",
						$time, twiddle_q[0].s, twiddle_q[0].c, twiddle_q[0].st,
						sin_value, cos_value, status);
				end
				void'(twiddle_q.pop_front());
			end
		end
	end

	int wdog;
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			wdog <= 0;
		end else begin
			wdog <= wdog + 1;
			if (wdog >= WDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send_word(logic k, logic [15:0] idx, bit known, twiddle_word_t typed);
		twiddle_word_t w;
		@(negedge clk);
		start <= 1'b1;
		kind <= k;
		index <= idx;
		do @(posedge clk); while (busy);
		w = twiddle_predict(k, idx);
		twiddle_q.push_back(known ? typed : w);
		n_words++;
		if (k) n_lookups++; else n_builds++;
	endtask

	task automatic idle_gap();
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (twiddle_q.size() != 0) @(posedge clk);
		do @(posedge clk); while (busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(logic [tfg_pkg::LEN_W-1:0] v);
		drain();
		@(negedge clk);
		length_we <= 1'b1;
		length_wdata <= v;
		@(negedge clk);
		length_we <= 1'b0;
		len_reg = v;
		tab_ready = 0;
		n_lens++;
	endtask

	initial begin
		twiddle_word_t typed;
		int unsigned len, n, nitems;
		logic [15:0] idx;
		errors = 0; n_words = 0; n_results = 0; n_builds = 0; n_lookups = 0; n_lens = 0;
		idle_pct = 0;
		tab_ready = 0;
		len_reg = 1;
		for (int i = 0; i < DEPTH; i++) begin
			tab_s[i] = 0; tab_c[i] = 0;
		end
		arst_n = 1'b0;
		start = 1'b0; kind = 1'b0; index = '0; length_we = 1'b0; length_wdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[r]) begin
			if (dir_tab[r].act == ROW_LEN) begin
				write_length(dir_tab[r].val[tfg_pkg::LEN_W-1:0]);
			end else begin
				typed.s = dir_tab[r].s;
				typed.c = dir_tab[r].c;
				typed.st = dir_tab[r].st;
				send_word(dir_tab[r].kind, dir_tab[r].val, dir_tab[r].known, typed);
			end
		end

		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: len = 4096;
				1: len = 0;
				2: len = 8191;
				3: len = 1;
				4: len = 2;
				5: len = 3;
				default: len = ($urandom_range(4) == 0) ? $urandom_range(65, 8191)
					: $urandom_range(1, 64);
			endcase
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 62;
				2: idle_pct = 0;
				default: idle_pct = 27;
			endcase
			write_length(len[tfg_pkg::LEN_W-1:0]);
			n = eff_length();
			if ($urandom_range(5) == 0) send_word(1'b1, 16'($urandom), 0, typed);
			send_word(1'b0, 16'($urandom), 0, typed);
			nitems = 92;
			for (int i = 0; i < nitems; i++) begin
				idle_gap();
				case ($urandom_range(9))
					0: idx = 16'($urandom_range(0, n - 1));
					1: idx = ($urandom_range(1)) ? 16'hFFFF : 16'(n - 1);
					2: idx = 16'(n / 4 + $urandom_range(0, 2));
					default: idx = 16'($urandom);
				endcase
				if ($urandom_range(39) == 0) send_word(1'b0, idx, 0, typed);
				else send_word(1'b1, idx, 0, typed);
				if ($urandom_range(49) == 0) drain();
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (twiddle_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("covered %0d words (%0d builds, %0d lookups), %0d results, %0d length writes",
			n_words, n_builds, n_lookups, n_results, n_lens);
		$display("lengths included 0, 1, 2, 3, 4096 and 8191, with and without sender gaps");
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
